### design/rmt_pkg.sv
package rmt_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int MEDIAN_W     = 33;
  localparam int COUNT_W      = 9;
  localparam int CAPACITY_DEF = 256;

  // Read address sources
  typedef enum logic [1:0] {
    RA_CNT_M1,
    RA_POS_M2,
    RA_LO,
    RA_HI
  } rd_sel_t;

  // Write address sources
  typedef enum logic {
    WA_COUNT,
    WA_POS
  } wa_sel_t;

  // Write data sources
  typedef enum logic {
    WD_SAMPLE,
    WD_SHIFT
  } wd_sel_t;

  typedef struct packed {
    logic    load_sample;
    logic    pos_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    count_inc;
    logic    cap_lo;
    logic    load_out;
  } rmt_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic gt;
    logic pos_one;
    logic out_busy;
  } rmt_status_t;

endpackage

### design/rmt_if.sv
interface rmt_in_if;
  import rmt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmt_out_if;
  import rmt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic        [COUNT_W-1:0]  stored_count;
  logic                       dropped;
  modport source (output valid, output median_doubled, output stored_count, output dropped,
                  input ready);
  modport sink (input valid, input median_doubled, input stored_count, input dropped,
                output ready);
endinterface

### design/rmt_ram.sv
module rmt_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/rmt_datapath.sv
module rmt_datapath import rmt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rmt_cmd_t                   cmd,
  output rmt_status_t                status,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [MEDIAN_W-1:0] out_median_doubled,
  output logic        [COUNT_W-1:0]  out_stored_count,
  output logic                       out_dropped
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]              count;
  logic [AW-1:0]              pos;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       drop;
  logic [SAMPLE_W-1:0]        lo;
  logic [SAMPLE_W-1:0]        rd_data;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic [SAMPLE_W-1:0]        wr_data;
  logic [CW-1:0]              half;
  logic [CW-1:0]              lo_idx;
  logic [CW-1:0]              cnt_m1;
  logic [CW+COUNT_W-1:0]      count_ext;

  // Middle indexes: hi is n/2, lo steps back one for an even count
  assign half   = count >> 1;
  assign lo_idx = half - {{(CW-1){1'b0}}, ~count[0]};
  assign cnt_m1 = count - {{(CW-1){1'b0}}, 1'b1};

  always_comb begin
    unique case (cmd.rd_sel)
      RA_CNT_M1: rd_addr = cnt_m1[AW-1:0];
      RA_POS_M2: rd_addr = pos - AW'(2);
      RA_LO:     rd_addr = lo_idx[AW-1:0];
      RA_HI:     rd_addr = half[AW-1:0];
      default:   rd_addr = half[AW-1:0];
    endcase
  end

  assign wr_addr = (cmd.wa_sel == WA_COUNT) ? count[AW-1:0] : pos;
  assign wr_data = (cmd.wd_sel == WD_SHIFT) ? rd_data : sample;

  rmt_ram #(.W(SAMPLE_W), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.count_inc) begin
        count <= count + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count};

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample <= in_sample;
      drop   <= status.full;
      pos    <= count[AW-1:0];
    end else if (cmd.pos_dec) begin
      pos <= pos - AW'(1);
    end
    if (cmd.cap_lo) begin
      lo <= rd_data;
    end
    if (cmd.load_out) begin
      out_median_doubled <= $signed({lo[SAMPLE_W-1], lo}) +
                            $signed({rd_data[SAMPLE_W-1], rd_data});
      out_stored_count   <= count_ext[COUNT_W-1:0];
      out_dropped        <= drop;
    end
  end

  assign status.full     = (count == CW'(CAPACITY));
  assign status.empty    = (count == '0);
  assign status.gt       = $signed(rd_data) > sample;
  assign status.pos_one  = (pos == AW'(1));
  assign status.out_busy = out_valid && !out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("sample count above capacity");
  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !cmd.count_inc)
    else $error("count grows while storage full");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_dropped) |-> status.full)
    else $error("drop reported with free storage");

endmodule

### design/rmt_ctrl.sv
module rmt_ctrl import rmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rmt_status_t status,
  output rmt_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_INSERT = 3'd2;
  localparam logic [2:0] S_MED_LO = 3'd3;
  localparam logic [2:0] S_MED_HI = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RA_CNT_M1;
    cmd.wa_sel = WA_POS;
    cmd.wd_sel = WD_SAMPLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          priority if (status.full) begin
            state_next = S_MED_LO;
          end else if (status.empty) begin
            // Write the registered sample into slot zero next cycle
            state_next = S_INSERT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_CNT_M1;
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // Move a larger neighbor up one slot, or drop the sample in place
        cmd.wr_en = 1'b1;
        if (status.gt) begin
          cmd.wd_sel  = WD_SHIFT;
          cmd.pos_dec = 1'b1;
          if (status.pos_one) begin
            state_next = S_INSERT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_POS_M2;
          end
        end else begin
          cmd.count_inc = 1'b1;
          state_next    = S_MED_LO;
        end
      end
      S_INSERT: begin
        cmd.wr_en     = 1'b1;
        cmd.count_inc = 1'b1;
        state_next    = S_MED_LO;
      end
      S_MED_LO: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_LO;
        state_next = S_MED_HI;
      end
      S_MED_HI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_HI;
        cmd.cap_lo = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the result register is free
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a sample while busy");
  a_no_write_on_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !cmd.wr_en)
    else $error("storage write during result load");
  a_shift_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> !status.full)
    else $error("shifting into full storage");

endmodule

### design/running_median_tracker.sv
// Running median tracker.
// in_ch carries one signed 32-bit sample per transfer; out_ch returns one result
// per sample: twice the median of all stored samples, the stored count and a
// dropped flag. Samples are kept in ascending order in one RAM of CAPACITY
// entries; a new sample is placed by moving each larger stored sample up one
// slot, one slot per cycle through the single RAM write port.
// After accept, each stored sample greater than the new one moves up one slot,
// the sample is written, the two middle entries are read and the result is
// loaded; when storage is full the sample is dropped and the unchanged
// median is reported.
// One sample is in work at a time; in_ch.ready returns the cycle after the
// result is loaded.
// The result sits in an output register; the block takes the next sample while
// it waits, and only stalls at the end of that sample if out_ch is still held.
// Reset (synchronous, active high) empties the store and clears out_ch.valid;
// no clearing pass is needed.
module running_median_tracker import rmt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rmt_in_if.sink    in_ch,
  rmt_out_if.source out_ch
);

  rmt_cmd_t    cmd;
  rmt_status_t status;

  rmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rmt_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .in_sample          (in_ch.sample),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_median_doubled (out_ch.median_doubled),
    .out_stored_count   (out_ch.stored_count),
    .out_dropped        (out_ch.dropped)
  );

endmodule
